@@ hw/rtl/nkd_pkg.sv @@
package nkd_pkg;

  localparam int unsigned ENTRIES_DEF    = 128;
  localparam int unsigned NAME_BYTES_DEF = 48;
  localparam int unsigned INODE_BITS_DEF = 16;

  localparam int unsigned NAME_WORDS = 6;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned INODE_IN_W = 16;
  localparam int unsigned SLOT_W     = 7;

  localparam logic [7:0] SLASH_BYTE = 8'h2F;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_RENAME = 2'd3
  } req_e;

  typedef struct packed {
    req_e                    req_type;
    logic [WORD_W-1:0]       name_word0;
    logic [WORD_W-1:0]       name_word1;
    logic [WORD_W-1:0]       name_word2;
    logic [WORD_W-1:0]       name_word3;
    logic [WORD_W-1:0]       name_word4;
    logic [WORD_W-1:0]       name_word5;
    logic [INODE_IN_W-1:0]   inode_num;
  } req_t;

  typedef struct packed {
    logic                    status;
    logic [INODE_IN_W-1:0]   found_inode;
    logic [SLOT_W-1:0]       slot;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic step;
    logic finish_pre;
    logic commit;
    logic miss;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pre_root;
    logic pre_fail;
    logic hit;
    logic last;
  } sts_t;

endpackage

@@ hw/rtl/nkd_ram.sv @@
module nkd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hw/rtl/nkd_dp.sv @@
module nkd_dp
  import nkd_pkg::*;
#(
  parameter int unsigned ENTRIES    = ENTRIES_DEF,
  parameter int unsigned NAME_BYTES = NAME_BYTES_DEF,
  parameter int unsigned INODE_BITS = INODE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  input  req_t in_req_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned NAME_W = NAME_BYTES * 8;
  localparam int unsigned ROW_W  = 1 + INODE_BITS + NAME_W;
  localparam int unsigned RAW_W  = NAME_WORDS * WORD_W;

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [NAME_W-1:0] ROOT_NAME = {{(NAME_W - 8){1'b0}}, SLASH_BYTE};
  localparam logic [ROW_W-1:0]  ROOT_ROW  = {1'b1, {INODE_BITS{1'b0}}, ROOT_NAME};

  logic [RAW_W-1:0]      raw;
  logic [NAME_BYTES-1:0] nz;
  logic [NAME_BYTES-1:0] keep;
  logic [NAME_W-1:0]     nm_in;
  logic [31:0]           inode_ext;

  req_e                  req_q;
  logic [NAME_W-1:0]     nm_q;
  logic [INODE_BITS-1:0] inum_q;

  logic [IDX_W-1:0]      clr_idx_q;
  logic [IDX_W-1:0]      rd_addr_q;
  logic                  rd_more_q;
  logic                  cmp_vld_q;
  logic [IDX_W-1:0]      cmp_idx_q;
  rsp_t                  res_q;
  rsp_t                  out_q;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [ROW_W-1:0]      ram_rdata;

  logic                  row_used;
  logic [INODE_BITS-1:0] row_inode;
  logic [NAME_W-1:0]     row_name;
  logic                  match;
  logic                  pre_empty;
  logic [31:0]           found_ext;
  logic [31:0]           slot_ext;

  assign raw = {in_req_i.name_word5, in_req_i.name_word4, in_req_i.name_word3,
                in_req_i.name_word2, in_req_i.name_word1, in_req_i.name_word0};

  // A byte survives only if it and every byte before it is non-zero.
  always_comb begin
    for (int b = 0; b < int'(NAME_BYTES); b++) begin
      nz[b] = |raw[8*b +: 8];
    end
    for (int b = 0; b < int'(NAME_BYTES); b++) begin
      keep[b] = &(nz | ~((NAME_BYTES'(2) << b) - NAME_BYTES'(1)));
    end
    for (int b = 0; b < int'(NAME_BYTES); b++) begin
      nm_in[8*b +: 8] = keep[b] ? raw[8*b +: 8] : 8'h00;
    end
  end

  assign inode_ext = 32'(in_req_i.inode_num);

  assign row_used  = ram_rdata[ROW_W-1];
  assign row_inode = ram_rdata[NAME_W +: INODE_BITS];
  assign row_name  = ram_rdata[NAME_W-1:0];

  always_comb begin
    case (req_q)
      REQ_INSERT: match = !row_used;
      REQ_RENAME: match = row_used && (row_inode == inum_q);
      default:    match = row_used && (row_name == nm_q);
    endcase
  end

  assign pre_empty       = (nm_q[7:0] == 8'h00);
  assign sts_o.clr_last  = (clr_idx_q == LAST_IDX);
  assign sts_o.pre_root  = !pre_empty && (req_q == REQ_LOOKUP) && (nm_q == ROOT_NAME);
  assign sts_o.pre_fail  = pre_empty || ((req_q == REQ_RENAME) && (inum_q == '0));
  assign sts_o.hit       = cmp_vld_q && match;
  assign sts_o.last      = cmp_vld_q && (cmp_idx_q == LAST_IDX);

  assign ram_re    = cmd_i.step && rd_more_q;
  assign ram_we    = cmd_i.clear || (cmd_i.commit && (req_q != REQ_LOOKUP));
  assign ram_waddr = cmd_i.clear ? clr_idx_q : cmp_idx_q;

  always_comb begin
    if (cmd_i.clear) begin
      ram_wdata = (clr_idx_q == '0) ? ROOT_ROW : '0;
    end else begin
      case (req_q)
        REQ_INSERT: ram_wdata = {1'b1, inum_q, nm_q};
        REQ_RENAME: ram_wdata = {1'b1, row_inode, nm_q};
        default:    ram_wdata = '0;
      endcase
    end
  end

  nkd_ram #(
    .WIDTH(ROW_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_addr_q),
    .rdata_o(ram_rdata)
  );

  assign found_ext = 32'(row_inode);
  assign slot_ext  = 32'(cmp_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
      rd_addr_q <= '0;
      rd_more_q <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_idx_q <= clr_idx_q + IDX_W'(1);
      end
      if (cmd_i.load) begin
        rd_addr_q <= '0;
        rd_more_q <= 1'b1;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.step) begin
        if (rd_more_q) begin
          rd_addr_q <= rd_addr_q + IDX_W'(1);
        end
        rd_more_q <= rd_more_q && (rd_addr_q != LAST_IDX);
        cmp_vld_q <= rd_more_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= in_req_i.req_type;
      nm_q   <= nm_in;
      inum_q <= inode_ext[INODE_BITS-1:0];
    end
    if (cmd_i.step) begin
      cmp_idx_q <= rd_addr_q;
    end
    if (cmd_i.finish_pre) begin
      res_q.status      <= sts_o.pre_fail ? STATUS_FAIL : STATUS_OK;
      res_q.found_inode <= '0;
      res_q.slot        <= '0;
    end else if (cmd_i.commit) begin
      res_q.status      <= STATUS_OK;
      res_q.found_inode <= (req_q == REQ_LOOKUP) ? found_ext[INODE_IN_W-1:0] : '0;
      res_q.slot        <= slot_ext[SLOT_W-1:0];
    end else if (cmd_i.miss) begin
      res_q.status      <= STATUS_FAIL;
      res_q.found_inode <= '0;
      res_q.slot        <= '0;
    end
    if (cmd_i.publish) begin
      out_q <= res_q;
    end
  end

  assign out_rsp_o = out_q;

endmodule

@@ hw/rtl/nkd_ctrl.sv @@
module nkd_ctrl
  import nkd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_HOLD
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.finish_pre = sts_i.pre_root || sts_i.pre_fail;
      end
      ST_SCAN: begin
        cmd_o.step   = 1'b1;
        cmd_o.commit = sts_i.hit;
        cmd_o.miss   = !sts_i.hit && sts_i.last;
      end
      ST_HOLD: begin
        cmd_o.publish = !out_valid_q || out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (sts_i.clr_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_q <= cmd_o.finish_pre ? ST_HOLD : ST_SCAN;
        end
        ST_SCAN: begin
          if (cmd_o.commit || cmd_o.miss) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (cmd_o.publish) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/name_keyed_directory_table_core.sv @@
// Channel | Direction | Payload   | Handshake
// request | in        | in_req_i  | in_valid_i / in_ready_o
// result  | out       | out_rsp_o | out_valid_o / out_ready_i
//
// After reset a clearing pass writes every entry of the table memory, one a cycle,
// and no request beat is taken until it ends.
// A request is checked, the entries are scanned in order and the result is published;
// the single read port of the entry memory serves one entry per cycle.
// Empty names, the root lookup and a rename of inode zero finish without a scan.
// The result waits in an output register, and the next request beat is taken once it
// is there; a further result is held back until that register has been read.
module name_keyed_directory_table_core
  import nkd_pkg::*;
#(
  parameter int unsigned ENTRIES    = ENTRIES_DEF,
  parameter int unsigned NAME_BYTES = NAME_BYTES_DEF,
  parameter int unsigned INODE_BITS = INODE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  cmd_t cmd;
  sts_t sts;

  nkd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nkd_dp #(
    .ENTRIES   (ENTRIES),
    .NAME_BYTES(NAME_BYTES),
    .INODE_BITS(INODE_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .in_req_i (in_req_i),
    .out_rsp_o(out_rsp_o)
  );

endmodule

@@ hw/rtl/nkd_checker.sv @@
module nkd_checker
  import nkd_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_rsp_o
);

  // A request beat occupies the block, so ready drops straight after it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while the previous one is still at work");

  a_fail_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == STATUS_FAIL) |->
      (out_rsp_o.found_inode == '0) && (out_rsp_o.slot == '0))
    else $error("failed result carries an inode or a slot");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result beat changed or vanished");

endmodule

bind name_keyed_directory_table_core nkd_checker u_nkd_checker (.*);
